### rtl/depth_test_blend_output_merge_assert.svh
// assertion macros shared by the raster output merge rtl
// no dependencies; pulled in by the files that carry assertions
`ifndef DEPTH_TEST_BLEND_OUTPUT_MERGE_ASSERT_SVH
`define DEPTH_TEST_BLEND_OUTPUT_MERGE_ASSERT_SVH

// same-cycle implication
`define DTBOM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DTBOM_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/dtbom_pkg.sv
// shared types and constants for the raster output merge block
// no dependencies
package dtbom_pkg;

   localparam int FRAME_WIDTH_DEF  = 256;
   localparam int FRAME_HEIGHT_DEF = 256;

   localparam int DEPTH_W     = 24;
   localparam int COLOR_W     = 32;
   localparam int CHAN_W      = 8;
   localparam int COORD_W     = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 2;
   localparam int FRAME_LIM_W = 13;

   localparam logic [DEPTH_W-1:0] FAR_DEPTH = 24'hFFFFFF;
   localparam logic [CHAN_W-1:0]  CHAN_MAX  = 8'hFF;

   // floor(v / 255) == (v * RECIP_255) >> RECIP_SHIFT for v below 132625
   localparam logic [17:0] RECIP_255   = 18'd131587;
   localparam int          RECIP_SHIFT = 25;
   localparam int          SUM_W       = 17;
   localparam int          QUOT_W      = 10;

   typedef enum logic [1:0] {
      ACT_FRAGMENT = 2'd0,
      ACT_READ     = 2'd1,
      ACT_CLEAR    = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      SRC_ONE   = 2'd0,
      SRC_ZERO  = 2'd1,
      SRC_ALPHA = 2'd2
   } src_factor_type;

   typedef enum logic [1:0] {
      DST_ONE     = 2'd0,
      DST_ZERO    = 2'd1,
      DST_INV_SRC = 2'd2
   } dst_factor_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DEPTH_WE   = 3'd0,
      CSR_COLOR_WE   = 3'd1,
      CSR_BLEND_EN   = 3'd2,
      CSR_SRC_FACTOR = 3'd3,
      CSR_DST_FACTOR = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CALC,
      ST_WRITE
   } state_type;

   typedef struct packed {
      src_factor_type source_factor;
      dst_factor_type dest_factor;
   } blend_cfg_type;

   typedef struct packed {
      logic          depth_write_enable;
      logic          color_write_enable;
      logic          blend_enable;
      blend_cfg_type blend;
   } cfg_type;

   typedef struct packed {
      action_type         action;
      logic               in_frame;
      logic [DEPTH_W-1:0] depth;
      logic [COLOR_W-1:0] color;
   } item_type;

endpackage

### rtl/dtbom_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module dtbom_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/dtbom_blend.sv
// two-stage color blend: factor products summed and registered, then divide by 255
// depends on dtbom_pkg
module dtbom_blend (
   input  logic                             clock,
   input  logic                             load,
   input  dtbom_pkg::blend_cfg_type         cfg,
   input  logic [dtbom_pkg::COLOR_W-1:0]    src_color,
   input  logic [dtbom_pkg::COLOR_W-1:0]    dst_color,
   output logic [dtbom_pkg::COLOR_W-1:0]    blended
);

   localparam int CW = dtbom_pkg::CHAN_W;
   localparam int PW = 2 * dtbom_pkg::CHAN_W;
   localparam int SW = dtbom_pkg::SUM_W;
   localparam int XW = SW + 18;

   logic [CW-1:0] src_f;
   logic [CW-1:0] dst_f;
   logic [PW-1:0] prod_s [4];
   logic [PW-1:0] prod_d [4];
   logic [SW-1:0] sum_in [4];
   logic [SW-1:0] sum_ff [4];
   logic [XW-1:0] scaled [4];
   logic [dtbom_pkg::QUOT_W-1:0] quot [4];

   always_comb begin
      case (cfg.source_factor)
         dtbom_pkg::SRC_ONE:   src_f = dtbom_pkg::CHAN_MAX;
         dtbom_pkg::SRC_ALPHA: src_f = src_color[3*CW +: CW];
         default:              src_f = '0;
      endcase
      case (cfg.dest_factor)
         dtbom_pkg::DST_ONE:     dst_f = dtbom_pkg::CHAN_MAX;
         dtbom_pkg::DST_INV_SRC: dst_f = dtbom_pkg::CHAN_MAX - src_f;
         default:                dst_f = '0;
      endcase
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         prod_s[k] = PW'(src_f) * PW'(src_color[k*CW +: CW]);
         prod_d[k] = PW'(dst_f) * PW'(dst_color[k*CW +: CW]);
         sum_in[k] = SW'(prod_s[k]) + SW'(prod_d[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sum_ff <= sum_in;
      end
   end

   // reciprocal multiply stands in for the divide, then saturate
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         scaled[k] = XW'(sum_ff[k]) * XW'(dtbom_pkg::RECIP_255);
         quot[k]   = scaled[k][dtbom_pkg::RECIP_SHIFT +: dtbom_pkg::QUOT_W];
         blended[k*CW +: CW] = (quot[k] > dtbom_pkg::QUOT_W'(dtbom_pkg::CHAN_MAX))
                               ? dtbom_pkg::CHAN_MAX : quot[k][CW-1:0];
      end
   end

endmodule

### rtl/depth_test_blend_output_merge.sv
// raster output merge top level: depth test, alpha blend, depth and color stores
// depends on dtbom_pkg, dtbom_ram, dtbom_blend and the assertion macro header
//
// Usage:
//   req_* channel takes one item: a fragment, a pixel read or a pixel clear.
//   rsp_* channel returns one item per request: pass flag plus the stored
//   pixel after the item (all zero for an unused action or a pixel outside
//   the frame). csr_* writes a config register; the user must write it only
//   while idle, which the block itself does not enforce. A new request is
//   taken only after the current item is through the read-modify-write of
//   the depth and color rams (read, blend products, divide and write back),
//   even while its result still waits in the output register; a stalled
//   result holds the block in its write-back step until the receiver frees
//   the output register. Reset: synchronous. Afterwards a clearing pass
//   writes far depth and zero color to all 2^(XW+YW) ram entries (65536 for
//   a 256 x 256 frame), one per cycle, with req_stall high. Config writes
//   are taken throughout. Pixel (x, y) lives at ram address {y, x} over the
//   bits the frame needs.

`include "depth_test_blend_output_merge_assert.svh"

module depth_test_blend_output_merge #(
   parameter int FRAME_WIDTH  = dtbom_pkg::FRAME_WIDTH_DEF,
   parameter int FRAME_HEIGHT = dtbom_pkg::FRAME_HEIGHT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_action,
   input  logic [dtbom_pkg::COORD_W-1:0]       req_pixel_x,
   input  logic [dtbom_pkg::COORD_W-1:0]       req_pixel_y,
   input  logic [dtbom_pkg::DEPTH_W-1:0]       req_frag_depth,
   input  logic [dtbom_pkg::CHAN_W-1:0]        req_frag_red,
   input  logic [dtbom_pkg::CHAN_W-1:0]        req_frag_green,
   input  logic [dtbom_pkg::CHAN_W-1:0]        req_frag_blue,
   input  logic [dtbom_pkg::CHAN_W-1:0]        req_frag_alpha,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_depth_passed,
   output logic [dtbom_pkg::CHAN_W-1:0]        rsp_out_red,
   output logic [dtbom_pkg::CHAN_W-1:0]        rsp_out_green,
   output logic [dtbom_pkg::CHAN_W-1:0]        rsp_out_blue,
   output logic [dtbom_pkg::CHAN_W-1:0]        rsp_out_alpha,
   output logic [dtbom_pkg::DEPTH_W-1:0]       rsp_out_depth,

   input  logic                                csr_write_enable,
   input  logic [dtbom_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [dtbom_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int CW    = dtbom_pkg::CHAN_W;
   localparam int DW    = dtbom_pkg::DEPTH_W;
   localparam int KW    = dtbom_pkg::COLOR_W;
   localparam int LW    = dtbom_pkg::FRAME_LIM_W;
   localparam int X_EXT = (FRAME_WIDTH > 256) ? 256 : FRAME_WIDTH;
   localparam int Y_EXT = (FRAME_HEIGHT > 256) ? 256 : FRAME_HEIGHT;
   localparam int XW    = (X_EXT > 2) ? $clog2(X_EXT) : 1;
   localparam int YW    = (Y_EXT > 2) ? $clog2(Y_EXT) : 1;
   localparam int AW    = XW + YW;
   localparam int DEPTH = 1 << AW;
   localparam logic [LW-1:0] X_LIM = LW'(FRAME_WIDTH);
   localparam logic [LW-1:0] Y_LIM = LW'(FRAME_HEIGHT);

   dtbom_pkg::state_type state_ff, state_in;
   dtbom_pkg::cfg_type   cfg_ff, cfg_in;
   dtbom_pkg::item_type  item_ff, item_in;
   logic [AW-1:0]        addr_ff, addr_in;
   logic [AW-1:0]        clear_ff, clear_in;

   logic                 req_accept;
   logic                 out_free;
   logic                 load_rsp;
   logic [AW-1:0]        rd_addr;
   logic                 mem_wr_en;
   logic [AW-1:0]        mem_wr_addr;
   logic [DW-1:0]        mem_wr_depth;
   logic [KW-1:0]        mem_wr_color;
   logic [DW-1:0]        stored_depth;
   logic [KW-1:0]        stored_color;
   logic [KW-1:0]        blended;

   logic                 wb_write;
   logic                 wb_passed;
   logic [DW-1:0]        wb_depth;
   logic [KW-1:0]        wb_color;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_passed_ff, rsp_passed_in;
   logic [KW-1:0]        rsp_color_ff, rsp_color_in;
   logic [DW-1:0]        rsp_depth_ff, rsp_depth_in;

   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign rd_addr    = {req_pixel_y[YW-1:0], req_pixel_x[XW-1:0]};

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (dtbom_pkg::csr_index_type'(csr_index))
            dtbom_pkg::CSR_DEPTH_WE:   cfg_in.depth_write_enable = csr_data[0];
            dtbom_pkg::CSR_COLOR_WE:   cfg_in.color_write_enable = csr_data[0];
            dtbom_pkg::CSR_BLEND_EN:   cfg_in.blend_enable       = csr_data[0];
            dtbom_pkg::CSR_SRC_FACTOR:
               cfg_in.blend.source_factor = dtbom_pkg::src_factor_type'(csr_data);
            dtbom_pkg::CSR_DST_FACTOR:
               cfg_in.blend.dest_factor = dtbom_pkg::dst_factor_type'(csr_data);
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dtbom_pkg::ST_CLEAR: begin
            if (clear_ff == '1) state_in = dtbom_pkg::ST_IDLE;
         end
         dtbom_pkg::ST_IDLE: begin
            if (req_valid) state_in = dtbom_pkg::ST_CALC;
         end
         dtbom_pkg::ST_CALC: begin
            state_in = dtbom_pkg::ST_WRITE;
         end
         dtbom_pkg::ST_WRITE: begin
            if (out_free) state_in = dtbom_pkg::ST_IDLE;
         end
         default: state_in = dtbom_pkg::ST_CLEAR;
      endcase
   end

   // state outputs
   always_comb begin
      req_stall = 1'b1;
      load_rsp  = 1'b0;
      clear_in  = clear_ff;
      unique case (state_ff)
         dtbom_pkg::ST_CLEAR: begin
            clear_in = clear_ff + AW'(1);
         end
         dtbom_pkg::ST_IDLE: begin
            req_stall = 1'b0;
         end
         dtbom_pkg::ST_CALC: begin
            req_stall = 1'b1;
         end
         dtbom_pkg::ST_WRITE: begin
            load_rsp = out_free;
         end
         default: req_stall = 1'b1;
      endcase
   end

   // item capture
   always_comb begin
      item_in = item_ff;
      addr_in = addr_ff;
      if (req_accept) begin
         item_in.action   = dtbom_pkg::action_type'(req_action);
         item_in.in_frame = ({5'd0, req_pixel_x} < X_LIM) && ({5'd0, req_pixel_y} < Y_LIM);
         item_in.depth    = req_frag_depth;
         item_in.color    = {req_frag_alpha, req_frag_blue, req_frag_green, req_frag_red};
         addr_in          = rd_addr;
      end
   end

   // write-back values; ram read data holds until the next accepted item
   always_comb begin
      wb_write  = 1'b0;
      wb_passed = 1'b0;
      wb_depth  = '0;
      wb_color  = '0;
      if (item_ff.in_frame) begin
         case (item_ff.action)
            dtbom_pkg::ACT_FRAGMENT: begin
               wb_passed = item_ff.depth < stored_depth;
               wb_write  = wb_passed;
               wb_depth  = stored_depth;
               wb_color  = stored_color;
               if (wb_passed && cfg_ff.depth_write_enable) begin
                  wb_depth = item_ff.depth;
               end
               if (wb_passed && cfg_ff.color_write_enable) begin
                  wb_color = cfg_ff.blend_enable ? blended : item_ff.color;
               end
            end
            dtbom_pkg::ACT_READ: begin
               wb_depth = stored_depth;
               wb_color = stored_color;
            end
            dtbom_pkg::ACT_CLEAR: begin
               wb_write = 1'b1;
               wb_depth = dtbom_pkg::FAR_DEPTH;
               wb_color = '0;
            end
            default: wb_write = 1'b0;
         endcase
      end
   end

   // the clearing pass shares the write port with write-back
   always_comb begin
      if (state_ff == dtbom_pkg::ST_CLEAR) begin
         mem_wr_en    = 1'b1;
         mem_wr_addr  = clear_ff;
         mem_wr_depth = dtbom_pkg::FAR_DEPTH;
         mem_wr_color = '0;
      end else begin
         mem_wr_en    = load_rsp && wb_write;
         mem_wr_addr  = addr_ff;
         mem_wr_depth = wb_depth;
         mem_wr_color = wb_color;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_passed_in = rsp_passed_ff;
      rsp_color_in  = rsp_color_ff;
      rsp_depth_in  = rsp_depth_ff;
      if (load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_passed_in = wb_passed;
         rsp_color_in  = wb_color;
         rsp_depth_in  = wb_depth;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dtbom_pkg::ST_CLEAR;
         clear_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         cfg_ff.depth_write_enable  <= 1'b1;
         cfg_ff.color_write_enable  <= 1'b1;
         cfg_ff.blend_enable        <= 1'b0;
         cfg_ff.blend.source_factor <= dtbom_pkg::SRC_ONE;
         cfg_ff.blend.dest_factor   <= dtbom_pkg::DST_ZERO;
      end else begin
         state_ff     <= state_in;
         clear_ff     <= clear_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      addr_ff       <= addr_in;
      rsp_passed_ff <= rsp_passed_in;
      rsp_color_ff  <= rsp_color_in;
      rsp_depth_ff  <= rsp_depth_in;
   end

   dtbom_ram #(
      .WIDTH (DW),
      .DEPTH (DEPTH)
   ) u_depth_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_depth),
      .rd_en   (req_accept),
      .rd_addr (rd_addr),
      .rd_data (stored_depth)
   );

   dtbom_ram #(
      .WIDTH (KW),
      .DEPTH (DEPTH)
   ) u_color_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_color),
      .rd_en   (req_accept),
      .rd_addr (rd_addr),
      .rd_data (stored_color)
   );

   dtbom_blend u_blend (
      .clock     (clock),
      .load      (state_ff == dtbom_pkg::ST_CALC),
      .cfg       (cfg_ff.blend),
      .src_color (item_ff.color),
      .dst_color (stored_color),
      .blended   (blended)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_depth_passed = rsp_passed_ff;
   assign rsp_out_red      = rsp_color_ff[0*CW +: CW];
   assign rsp_out_green    = rsp_color_ff[1*CW +: CW];
   assign rsp_out_blue     = rsp_color_ff[2*CW +: CW];
   assign rsp_out_alpha    = rsp_color_ff[3*CW +: CW];
   assign rsp_out_depth    = rsp_depth_ff;

   `DTBOM_ASSERT_IMP(a_no_rsp_in_clear, clock, reset,
      state_ff == dtbom_pkg::ST_CLEAR, !rsp_valid_ff, "result valid during clearing pass")
   `DTBOM_ASSERT_NXT(a_accept_starts, clock, reset,
      req_valid && !req_stall, state_ff == dtbom_pkg::ST_CALC, "accepted item did not start")
   `DTBOM_ASSERT_IMP(a_write_window, clock, reset, mem_wr_en,
      state_ff == dtbom_pkg::ST_CLEAR || (state_ff == dtbom_pkg::ST_WRITE && out_free),
      "ram write outside clear or write-back")
   `DTBOM_ASSERT_NXT(a_wb_waits, clock, reset,
      state_ff == dtbom_pkg::ST_WRITE && rsp_valid_ff && rsp_stall,
      state_ff == dtbom_pkg::ST_WRITE, "write-back left while output register full")

endmodule

### test/tb_depth_test_blend_output_merge.sv
// self-checking bench for the raster output merge block: depth test, blend, stores
// depends on dtbom_pkg and depth_test_blend_output_merge; a tracker class mirrors both stores
`timescale 1ns / 100ps

module tb_depth_test_blend_output_merge;
   import dtbom_pkg::*;

   localparam logic [1:0] ACT_UNUSED    = 2'd3;
   localparam logic [1:0] FACTOR_UNUSED = 2'd3;
   localparam int         CYCLE_LIMIT   = 600000;
   localparam int         RANDOM_PHASES = 8;
   localparam int         PHASE_ITEMS   = 200;
   localparam int         HOLD_CYCLES   = 400;
   localparam int         HOLD_AFTER    = 600;

   typedef struct packed {
      logic               passed;
      logic [CHAN_W-1:0]  red;
      logic [CHAN_W-1:0]  green;
      logic [CHAN_W-1:0]  blue;
      logic [CHAN_W-1:0]  alpha;
      logic [DEPTH_W-1:0] depth;
   } pixel_result_type;

   class pixel_merge_tracker;
      bit [DEPTH_W-1:0]   depth_mem [0:65535];
      bit [COLOR_W-1:0]   color_mem [0:65535];
      bit                 depth_we;
      bit                 color_we;
      bit                 blend_on;
      logic [1:0]         src_code;
      logic [1:0]         dst_code;
      pixel_result_type   expected_pixels [$];
      int                 accepted_items;
      int                 errors;

      function new();
         foreach (depth_mem[i]) begin
            depth_mem[i] = FAR_DEPTH;
            color_mem[i] = '0;
         end
         depth_we = 1'b1;
         color_we = 1'b1;
         blend_on = 1'b0;
         src_code = SRC_ONE;
         dst_code = DST_ZERO;
         accepted_items = 0;
         errors = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_DEPTH_WE:   depth_we = val[0];
            CSR_COLOR_WE:   color_we = val[0];
            CSR_BLEND_EN:   blend_on = val[0];
            CSR_SRC_FACTOR: src_code = val;
            CSR_DST_FACTOR: dst_code = val;
            default: ;
         endcase
      endfunction

      function bit [DEPTH_W-1:0] depth_at(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
         return depth_mem[{y, x}];
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction

      function void note_item(logic [1:0] act, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                              logic [DEPTH_W-1:0] z, logic [COLOR_W-1:0] frag);
         pixel_result_type res;
         logic [15:0]      addr;
         logic [COLOR_W-1:0] mixed;
         int unsigned      sf;
         int unsigned      df;
         int unsigned      v;
         res = '0;
         addr = {y, x};
         accepted_items++;
         // every 8-bit coordinate lies inside a 256 x 256 frame
         if (act != ACT_UNUSED) begin
            case (act)
               ACT_FRAGMENT: begin
                  if (z < depth_mem[addr]) begin
                     res.passed = 1'b1;
                     mixed = frag;
                     if (blend_on) begin
                        case (src_code)
                           SRC_ONE:   sf = 32'(CHAN_MAX);
                           SRC_ALPHA: sf = 32'(frag[31:24]);
                           default:   sf = 0;
                        endcase
                        case (dst_code)
                           DST_ONE:     df = 32'(CHAN_MAX);
                           DST_INV_SRC: df = 32'(CHAN_MAX) - sf;
                           default:     df = 0;
                        endcase
                        for (int k = 0; k < 4; k++) begin
                           v = (sf * 32'(frag[8*k +: 8])
                                + df * 32'(color_mem[addr][8*k +: 8])) / 32'(CHAN_MAX);
                           mixed[8*k +: 8] = (v > 32'(CHAN_MAX)) ? CHAN_MAX : v[7:0];
                        end
                     end
                     if (depth_we)
                        depth_mem[addr] = z;
                     if (color_we)
                        color_mem[addr] = mixed;
                  end
               end
               ACT_CLEAR: begin
                  depth_mem[addr] = FAR_DEPTH;
                  color_mem[addr] = '0;
               end
               default: ;
            endcase
            res.red   = color_mem[addr][7:0];
            res.green = color_mem[addr][15:8];
            res.blue  = color_mem[addr][23:16];
            res.alpha = color_mem[addr][31:24];
            res.depth = depth_mem[addr];
         end
         expected_pixels.insert(expected_pixels.size(), res);
      endfunction

      function void check_pixel(pixel_result_type got);
         pixel_result_type want;
         if (expected_pixels.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result: passed=%0d rgba=%h %h %h %h depth=%h",
                        got.passed, got.red, got.green, got.blue, got.alpha, got.depth);
         end else begin
            want = expected_pixels.pop_front();
            if (got !== want) begin
               errors++;
               if (errors <= 10)
                  $display({"mismatch: expected passed=%0d rgba=%h %h %h %h depth=%h,",
                            " got passed=%0d rgba=%h %h %h %h depth=%h"},
                           want.passed, want.red, want.green, want.blue, want.alpha,
                           want.depth, got.passed, got.red, got.green, got.blue,
                           got.alpha, got.depth);
            end
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [1:0]             req_action;
   logic [COORD_W-1:0]     req_pixel_x;
   logic [COORD_W-1:0]     req_pixel_y;
   logic [DEPTH_W-1:0]     req_frag_depth;
   logic [CHAN_W-1:0]      req_frag_red;
   logic [CHAN_W-1:0]      req_frag_green;
   logic [CHAN_W-1:0]      req_frag_blue;
   logic [CHAN_W-1:0]      req_frag_alpha;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic                   rsp_depth_passed;
   logic [CHAN_W-1:0]      rsp_out_red;
   logic [CHAN_W-1:0]      rsp_out_green;
   logic [CHAN_W-1:0]      rsp_out_blue;
   logic [CHAN_W-1:0]      rsp_out_alpha;
   logic [DEPTH_W-1:0]     rsp_out_depth;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   pixel_merge_tracker tracker = new();
   int                 cycle_count = 0;
   bit                 hold_done = 1'b0;

   depth_test_blend_output_merge dut (.*);

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            tracker.note_item(req_action, req_pixel_x, req_pixel_y, req_frag_depth,
                              {req_frag_alpha, req_frag_blue, req_frag_green, req_frag_red});
         if (rsp_valid && !rsp_stall)
            tracker.check_pixel({rsp_depth_passed, rsp_out_red, rsp_out_green,
                                 rsp_out_blue, rsp_out_alpha, rsp_out_depth});
      end
   end

   // receiver: segments of free flow, light and heavy stall, toggling, plus one long hold
   initial begin
      int seg_len;
      int mode;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         if (!hold_done && tracker.accepted_items >= HOLD_AFTER) begin
            hold_done = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock) rsp_stall = 1'b1;
         end else begin
            seg_len = $urandom_range(10, 120);
            mode = $urandom_range(0, 3);
            repeat (seg_len) begin
               @(negedge clock);
               case (mode)
                  0: rsp_stall = 1'b0;
                  1: rsp_stall = ($urandom_range(0, 3) == 0);
                  2: rsp_stall = ($urandom_range(0, 3) != 0);
                  default: rsp_stall = ~rsp_stall;
               endcase
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL");
      $finish;
   end

   task automatic send_item(logic [1:0] act, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                            logic [DEPTH_W-1:0] z, logic [COLOR_W-1:0] color);
      @(negedge clock);
      req_valid      = 1'b1;
      req_action     = act;
      req_pixel_x    = x;
      req_pixel_y    = y;
      req_frag_depth = z;
      req_frag_red   = color[7:0];
      req_frag_green = color[15:8];
      req_frag_blue  = color[23:16];
      req_frag_alpha = color[31:24];
      do @(posedge clock); while (req_stall);
   endtask

   task automatic idle_req(int cycles);
      repeat (cycles) @(negedge clock) req_valid = 1'b0;
   endtask

   task automatic wait_idle();
      idle_req(1);
      while (tracker.pending() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_data         = val;
      @(posedge clock);
      tracker.write_reg(idx, val);
      @(negedge clock) csr_write_enable = 1'b0;
   endtask

   task automatic apply_setup(logic dwe, logic cwe, logic blend, logic [1:0] sf,
                              logic [1:0] df);
      wait_idle();
      set_reg(CSR_DEPTH_WE, {1'b0, dwe});
      set_reg(CSR_COLOR_WE, {1'b0, cwe});
      set_reg(CSR_BLEND_EN, {1'b0, blend});
      set_reg(CSR_SRC_FACTOR, sf);
      set_reg(CSR_DST_FACTOR, df);
   endtask

   task automatic run_random_phase(int count);
      logic [COORD_W-1:0] pool_x [8];
      logic [COORD_W-1:0] pool_y [8];
      logic [1:0]         act;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [DEPTH_W-1:0] z;
      logic [DEPTH_W-1:0] stored;
      logic [COLOR_W-1:0] color;
      int                 pick;
      int                 sent;
      int                 slot;
      foreach (pool_x[i]) begin
         pool_x[i] = COORD_W'($urandom);
         pool_y[i] = COORD_W'($urandom);
      end
      sent = 0;
      while (sent < count) begin
         repeat ($urandom_range(1, 24)) begin
            pick = $urandom_range(0, 99);
            act = (pick < 70) ? ACT_FRAGMENT : (pick < 80) ? ACT_READ :
                  (pick < 92) ? ACT_CLEAR : ACT_UNUSED;
            // a small pool of pixels keeps the depth test busy on revisits
            if ($urandom_range(0, 3) == 0) begin
               x = COORD_W'($urandom);
               y = COORD_W'($urandom);
            end else begin
               slot = $urandom_range(0, 7);
               x = pool_x[slot];
               y = pool_y[slot];
            end
            stored = tracker.depth_at(x, y);
            case ($urandom_range(0, 15))
               0, 1:       z = stored;
               2, 3:       z = stored - DEPTH_W'(1);
               4:          z = '0;
               5:          z = FAR_DEPTH;
               6, 7, 8, 9: z = stored - DEPTH_W'($urandom_range(0, 1023));
               default:    z = DEPTH_W'($urandom);
            endcase
            color = $urandom;
            if ($urandom_range(0, 3) == 0)
               color[31:24] = $urandom_range(0, 1) ? CHAN_MAX : '0;
            send_item(act, x, y, z, color);
            if (act != ACT_UNUSED)
               sent++;
         end
         if ($urandom_range(0, 2) != 0)
            idle_req($urandom_range(1, 8));
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_action       = '0;
      req_pixel_x      = '0;
      req_pixel_y      = '0;
      req_frag_depth   = '0;
      req_frag_red     = '0;
      req_frag_green   = '0;
      req_frag_blue    = '0;
      req_frag_alpha   = '0;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_data         = '0;
      repeat (7) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      // reset settings: plain depth-tested writes
      send_item(ACT_READ, 8'h00, 8'h00, '0, '0);
      send_item(ACT_FRAGMENT, 8'h00, 8'h00, 24'h800000, 32'h80C04020);
      send_item(ACT_FRAGMENT, 8'h00, 8'h00, 24'h800000, 32'hFFFFFFFF);
      send_item(ACT_FRAGMENT, 8'h00, 8'h00, 24'h7FFFFF, 32'h40FF00FF);
      send_item(ACT_FRAGMENT, 8'hFF, 8'hFF, FAR_DEPTH, 32'hFFFFFFFF);
      send_item(ACT_FRAGMENT, 8'hFF, 8'hFF, 24'h000000, 32'hFFFFFFFF);
      send_item(ACT_FRAGMENT, 8'hFF, 8'hFF, 24'h000000, 32'h00000000);
      send_item(ACT_UNUSED, 8'h00, 8'h00, FAR_DEPTH, 32'hFFFFFFFF);
      send_item(ACT_CLEAR, 8'hFF, 8'hFF, 24'h000000, 32'hFFFFFFFF);
      send_item(ACT_READ, 8'hFF, 8'hFF, 24'h000000, 32'h00000000);
      send_item(ACT_FRAGMENT, 8'hFF, 8'h00, FAR_DEPTH - DEPTH_W'(1), 32'h12345678);
      send_item(ACT_FRAGMENT, 8'h00, 8'hFF, 24'h000001, 32'h00000000);

      // additive blend saturates
      apply_setup(1'b1, 1'b1, 1'b1, SRC_ONE, DST_ONE);
      send_item(ACT_FRAGMENT, 8'h00, 8'h00, 24'h100000, 32'hC0C0C0C0);

      apply_setup(1'b1, 1'b1, 1'b1, SRC_ALPHA, DST_INV_SRC);
      send_item(ACT_FRAGMENT, 8'h00, 8'h00, 24'h080000, 32'h802060A0);
      send_item(ACT_FRAGMENT, 8'h00, 8'h00, 24'h040000, 32'h00FFFFFF);
      send_item(ACT_FRAGMENT, 8'h00, 8'h00, 24'h020000, 32'hFF102030);

      // unused factor codes act as zero
      apply_setup(1'b0, 1'b1, 1'b1, FACTOR_UNUSED, FACTOR_UNUSED);
      send_item(ACT_FRAGMENT, 8'h00, 8'h00, 24'h010000, 32'hFFFFFFFF);
      send_item(ACT_READ, 8'h00, 8'h00, 24'h000000, 32'h00000000);

      apply_setup(1'b1, 1'b0, 1'b1, SRC_ZERO, DST_ZERO);
      send_item(ACT_FRAGMENT, 8'h10, 8'h20, 24'h000010, 32'hA5A5A5A5);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: apply_setup(1'b0, 1'b0, 1'b0, SRC_ONE, DST_ONE);
            1: apply_setup(1'b1, 1'b1, 1'b1, FACTOR_UNUSED, FACTOR_UNUSED);
            2: apply_setup(1'b1, 1'b1, 1'b1, SRC_ALPHA, DST_INV_SRC);
            3: apply_setup(1'b1, 1'b1, 1'b1, SRC_ONE, DST_ONE);
            default: begin
               wait_idle();
               // random data also exercises masking of the one-bit registers
               for (int r = CSR_DEPTH_WE; r <= CSR_DST_FACTOR; r++)
                  set_reg(CSR_INDEX_W'(r), CSR_DATA_W'($urandom_range(0, 3)));
               set_reg(CSR_INDEX_W'($urandom_range(CSR_DST_FACTOR + 1,
                                                   (1 << CSR_INDEX_W) - 1)),
                       CSR_DATA_W'($urandom_range(0, 3)));
            end
         endcase
         run_random_phase(PHASE_ITEMS);
      end

      idle_req(1);
      while (tracker.pending() > 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

### depth_test_blend_output_merge.f
+incdir+rtl
rtl/dtbom_pkg.sv
rtl/dtbom_ram.sv
rtl/dtbom_blend.sv
rtl/depth_test_blend_output_merge.sv
test/tb_depth_test_blend_output_merge.sv
